[hdl/usb_midi_sysex_packetizer_defines.svh]
// assertion macros shared by the packetizer modules
`ifndef USB_MIDI_SYSEX_PACKETIZER_DEFINES_SVH
`define USB_MIDI_SYSEX_PACKETIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define USMP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define USMP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define USMP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define USMP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/usmp_pkg.sv]
// types and constants of the usb midi sysex packetizer
package usmp_pkg;

  localparam int MAX_ID_BYTES = 3;

  localparam logic [7:0] START_BYTE = 8'hF0;
  localparam logic [7:0] END_BYTE   = 8'hF7;

  localparam logic [2:0] CODE_CONTINUE = 3'h4;
  localparam logic [2:0] CODE_END_BASE = 3'h5;

  localparam logic [1:0] REG_ID_LENGTH  = 2'd0;
  localparam logic [1:0] REG_ID_FIRST   = 2'd1;
  localparam logic [1:0] REG_ID_SECOND  = 2'd2;
  localparam logic [1:0] REG_ID_THIRD   = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] code;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic       fin;
  } packet_t;

  typedef struct packed {
    packet_t pkt0;
    packet_t pkt1;
    logic    two;
  } job_t;

endpackage

[hdl/usmp_queue.sv]
// short job queue between the front and back parts
`include "usb_midi_sysex_packetizer_defines.svh"

module usmp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  usmp_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output usmp_pkg::job_t rd_job
);
  import usmp_pkg::*;

  job_t              jobs [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = jobs[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      jobs[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

  `USMP_ASSERT_IMP(a_no_push_full, clk, rst, push, !full, "push into full queue")
  `USMP_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, rd_valid, "pop from empty queue")

endmodule

[hdl/usmp_front.sv]
// front part: config registers, header insertion and packet framing
`include "usb_midi_sysex_packetizer_defines.svh"

module usmp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [6:0]     cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic           carries_byte,
  input  logic           end_of_payload,
  input  logic           q_full,
  output logic           push,
  output usmp_pkg::job_t job
);
  import usmp_pkg::*;

  logic [1:0] id_length;
  logic [6:0] id_first;
  logic [6:0] id_second;
  logic [6:0] id_third;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic [1:0] pend_count;
  logic       in_msg;

  logic [7:0] stream [0:7];
  logic [2:0] n;
  logic [2:0] rem;
  logic [1:0] ids;
  logic       acc;
  logic       active;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign active   = carries_byte || end_of_payload;
  assign ids      = (id_length > 2'(MAX_ID_BYTES)) ? 2'(MAX_ID_BYTES) : id_length;
  assign rem      = 3'(n - 3'd3);

  // byte stream of this item: pending or header, then data, then end byte
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      stream[i] = '0;
    end
    if (in_msg) begin
      stream[0] = pend0;
      stream[1] = pend1;
      n         = {1'b0, pend_count};
    end else begin
      stream[0] = START_BYTE;
      stream[1] = (ids >= 2'd1) ? {1'b0, id_first}  : 8'd0;
      stream[2] = (ids >= 2'd2) ? {1'b0, id_second} : 8'd0;
      stream[3] = (ids >= 2'd3) ? {1'b0, id_third}  : 8'd0;
      n         = 3'(3'd1 + {1'b0, ids});
    end
    if (carries_byte) begin
      stream[n] = data_byte;
      n         = 3'(n + 3'd1);
    end
    if (end_of_payload) begin
      stream[n] = END_BYTE;
      n         = 3'(n + 3'd1);
    end
  end

  always_comb begin
    job.pkt0 = '{code: CODE_CONTINUE, byte_a: stream[0], byte_b: stream[1],
                 byte_c: stream[2], fin: 1'b0};
    job.pkt1 = '{code: CODE_CONTINUE, byte_a: stream[3], byte_b: stream[4],
                 byte_c: stream[5], fin: 1'b1};
    job.two  = 1'b0;
    push     = 1'b0;
    if (end_of_payload) begin
      push = acc;
      if (n > 3'd3) begin
        job.two       = 1'b1;
        job.pkt1.code = 3'(CODE_END_BASE + rem - 3'd1);
      end else begin
        job.pkt0.code = 3'(CODE_END_BASE + n - 3'd1);
        job.pkt0.fin  = 1'b1;
      end
    end else begin
      push = acc && carries_byte && (n >= 3'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_length <= '0;
      id_first  <= '0;
      id_second <= '0;
      id_third  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ID_LENGTH: id_length <= cfg_data[1:0];
        REG_ID_FIRST:  id_first  <= cfg_data;
        REG_ID_SECOND: id_second <= cfg_data;
        REG_ID_THIRD:  id_third  <= cfg_data;
        default:       id_length <= id_length;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg     <= 1'b0;
      pend_count <= '0;
      pend0      <= '0;
      pend1      <= '0;
    end else if (acc && active) begin
      if (end_of_payload) begin
        in_msg     <= 1'b0;
        pend_count <= '0;
        pend0      <= '0;
        pend1      <= '0;
      end else begin
        in_msg <= 1'b1;
        if (n >= 3'd3) begin
          pend0      <= stream[3];
          pend1      <= stream[4];
          pend_count <= 2'(rem);
        end else begin
          pend0      <= stream[0];
          pend1      <= stream[1];
          pend_count <= 2'(n);
        end
      end
    end
  end

  `USMP_ASSERT_IMP(a_idle_no_pending, clk, rst, !in_msg, pend_count == 2'd0,
    "pending bytes outside a message")
  `USMP_ASSERT_IMP(a_pending_range, clk, rst, 1'b1, pend_count != 2'd3,
    "pending count beyond two")
  `USMP_ASSERT_NXT(a_end_closes, clk, rst, acc && end_of_payload, !in_msg,
    "message not closed after end mark")

endmodule

[hdl/usmp_back.sv]
// back part: unpacks queued jobs into the registered packet output
`include "usb_midi_sysex_packetizer_defines.svh"

module usmp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  usmp_pkg::job_t q_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output usmp_pkg::packet_t out_pkt
);
  import usmp_pkg::*;

  logic half;
  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = load && q_valid && (half || !q_job.two);

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_pkt <= half ? q_job.pkt1 : q_job.pkt0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        half <= !pop;
      end
    end
  end

  `USMP_ASSERT_IMP(a_half_has_job, clk, rst, half, q_valid && q_job.two,
    "second packet pending without a two-packet job")

endmodule

[hdl/usb_midi_sysex_packetizer.sv]
// top level of the usb midi sysex packetizer
// Frames a system-exclusive payload into 4-byte USB MIDI event packets. One
// input item (one payload byte, or an empty item that only closes the
// message) is taken every cycle while the queue is not full. The first item
// of a message inserts 0xF0 and id_length identifier bytes; the end mark
// appends 0xF7. Each item yields zero, one or two packets, which the front
// part computes in the cycle of acceptance and pushes as one job into a
// 4-entry queue. The back part sends one packet per cycle from its output
// register while m_tready is high, so a two-packet item holds the output
// for both packets while the queue keeps taking items; input stalls only
// when the queue is full. Each packet passes through the queue and then the
// output register. Configuration writes are taken in any cycle (cfg_ready
// is always high) and must be done only while the block is idle.
module usb_midi_sysex_packetizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // data_byte
  input  logic        s_tuser,  // carries_byte
  input  logic        s_tlast,  // end_of_payload
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // midi_byte_a, midi_byte_b, midi_byte_c
  output logic [2:0]  m_tuser,  // code_index
  output logic        m_tlast   // final_packet
);
  import usmp_pkg::*;

  job_t    f_job;
  job_t    q_job;
  packet_t out_pkt;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_valid;

  assign cfg_ready = 1'b1;

  usmp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .data_byte      (s_tdata),
    .carries_byte   (s_tuser),
    .end_of_payload (s_tlast),
    .q_full         (q_full),
    .push           (push),
    .job            (f_job)
  );

  usmp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (f_job),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  usmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pkt   (out_pkt)
  );

  assign m_tdata = {out_pkt.byte_c, out_pkt.byte_b, out_pkt.byte_a};
  assign m_tuser = out_pkt.code;
  assign m_tlast = out_pkt.fin;

endmodule

[tb/usb_midi_sysex_packetizer_tb.sv]
// testbench of the usb midi sysex packetizer: directed table, random messages, packet checks
module usb_midi_sysex_packetizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import usmp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 130;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 8;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] id_count;
    logic [6:0] id0;
    logic [6:0] id1;
    logic [6:0] id2;
    logic [7:0] data;
    logic       has;
    logic       last;
    int         typed;    // -1: from predictor
    packet_t    p0;
    packet_t    p1;
  } dir_row_t;

  localparam packet_t NO_PKT = '0;
  localparam int N_DIRECTED = 25;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;  // data_byte
  logic        s_tuser = 1'b0;  // carries_byte
  logic        s_tlast = 1'b0;  // end_of_payload
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;  // midi_byte_a, midi_byte_b, midi_byte_c
  logic [2:0]  m_tuser;  // code_index
  logic        m_tlast;  // final_packet

  usb_midi_sysex_packetizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // predictor state and configuration
  logic [1:0] id_len;
  logic [7:0] id_val [3];
  logic [7:0] held [2];
  int         held_cnt;
  logic       in_msg;

  packet_t packets_due [$];
  packet_t got;
  packet_t want;

  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  dir_row_t directed [N_DIRECTED] = '{
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1,
      '{CODE_END_BASE + 3'd1, 8'hF0, 8'hF7, 8'h00, 1'b1}, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h5A, 1'b0, 1'b0, 0, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h00, 1'b1, 1'b0, 0, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'hFF, 1'b1, 1'b1, 2,
      '{CODE_CONTINUE, 8'hF0, 8'h00, 8'hFF, 1'b0},
      '{CODE_END_BASE, 8'hF7, 8'h00, 8'h00, 1'b1}},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h80, 1'b1, 1'b1, 1,
      '{CODE_END_BASE + 3'd2, 8'hF0, 8'h80, 8'hF7, 1'b1}, NO_PKT},
    '{ROW_CFG,  2'd3, 7'h7F, 7'h00, 7'h55, 8'h00, 1'b0, 1'b0, 0, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h12, 1'b1, 1'b0, 1,
      '{CODE_CONTINUE, 8'hF0, 8'h7F, 8'h00, 1'b0}, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h34, 1'b1, 1'b0, 1,
      '{CODE_CONTINUE, 8'h55, 8'h12, 8'h34, 1'b0}, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1,
      '{CODE_END_BASE, 8'hF7, 8'h00, 8'h00, 1'b1}, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'hAA, 1'b1, 1'b1, 2,
      '{CODE_CONTINUE, 8'hF0, 8'h7F, 8'h00, 1'b0},
      '{CODE_END_BASE + 3'd2, 8'h55, 8'hAA, 8'hF7, 1'b1}},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h00, 1'b0, 1'b1, 2,
      '{CODE_CONTINUE, 8'hF0, 8'h7F, 8'h00, 1'b0},
      '{CODE_END_BASE + 3'd1, 8'h55, 8'hF7, 8'h00, 1'b1}},
    '{ROW_CFG,  2'd1, 7'h2A, 7'h01, 7'h7E, 8'h00, 1'b0, 1'b0, 0, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h01, 1'b1, 1'b0, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h7F, 1'b1, 1'b0, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'hFE, 1'b1, 1'b0, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h55, 1'b1, 1'b0, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'hAA, 1'b0, 1'b0, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'hC3, 1'b1, 1'b1, -1, NO_PKT, NO_PKT},
    '{ROW_CFG,  2'd2, 7'h40, 7'h3F, 7'h00, 8'h00, 1'b0, 1'b0, 0, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h11, 1'b1, 1'b0, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h00, 1'b0, 1'b1, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'h00, 1'b0, 1'b1, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'hF7, 1'b1, 1'b0, -1, NO_PKT, NO_PKT},
    '{ROW_ITEM, 2'd0, 7'h00, 7'h00, 7'h00, 8'hF0, 1'b1, 1'b1, -1, NO_PKT, NO_PKT},
    '{ROW_CFG,  2'd0, 7'h00, 7'h00, 7'h00, 8'h00, 1'b0, 1'b0, 0, NO_PKT, NO_PKT}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // frames one item into packets and advances the predictor state
  function automatic int frame_item(input logic [7:0] d, input logic has, input logic last,
                                    output packet_t p0, output packet_t p1);
    logic [7:0] bs [8];
    int n;
    int pos;
    int k;
    int take;
    int ids;
    packet_t pk;
    n = 0;
    pos = 0;
    k = 0;
    p0 = '0;
    p1 = '0;
    if (!has && !last) return 0;
    for (int i = 0; i < held_cnt; i++) begin
      bs[n] = held[i];
      n++;
    end
    if (!in_msg) begin
      ids = (id_len > MAX_ID_BYTES) ? MAX_ID_BYTES : int'(id_len);
      bs[n] = START_BYTE;
      n++;
      for (int i = 0; i < ids; i++) begin
        bs[n] = id_val[i];
        n++;
      end
      in_msg = 1'b1;
    end
    if (has) begin
      bs[n] = d;
      n++;
    end
    if (last) begin
      bs[n] = END_BYTE;
      n++;
    end
    while ((last ? (n - pos > 3) : (n - pos >= 3)) && k < 2) begin
      pk = '{CODE_CONTINUE, bs[pos], bs[pos + 1], bs[pos + 2], 1'b0};
      if (k == 0) p0 = pk;
      else p1 = pk;
      k++;
      pos += 3;
    end
    if (last) begin
      take = n - pos;
      pk.code   = CODE_END_BASE + 3'(take - 1);
      pk.byte_a = bs[pos];
      pk.byte_b = (take > 1) ? bs[pos + 1] : 8'h00;
      pk.byte_c = (take > 2) ? bs[pos + 2] : 8'h00;
      pk.fin    = 1'b1;
      if (k == 0) p0 = pk;
      else p1 = pk;
      k++;
      held_cnt = 0;
      held[0] = 8'h00;
      held[1] = 8'h00;
      in_msg = 1'b0;
    end else begin
      held_cnt = n - pos;
      held[0] = (held_cnt > 0) ? bs[pos] : 8'h00;
      held[1] = (held_cnt > 1) ? bs[pos + 1] : 8'h00;
    end
    return k;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (packets_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_ids(input logic [1:0] len, input logic [6:0] a, input logic [6:0] b,
                         input logic [6:0] c);
    logic [1:0] idx [4];
    logic [6:0] val [4];
    idx = '{REG_ID_LENGTH, REG_ID_FIRST, REG_ID_SECOND, REG_ID_THIRD};
    val = '{7'(len), a, b, c};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    id_len = len;
    id_val[0] = {1'b0, a};
    id_val[1] = {1'b0, b};
    id_val[2] = {1'b0, c};
  endtask

  // offers one item, waits for the request to be taken, then predicts
  task automatic send_item(input logic [7:0] d, input logic has, input logic last,
                           input int typed, input packet_t t0, input packet_t t1);
    packet_t p0;
    packet_t p1;
    int k;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= has;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    k = frame_item(d, has, last, p0, p1);
    if (typed >= 0) begin
      k = typed;
      p0 = t0;
      p1 = t1;
    end
    if (k > 0) packets_due.push_back(p0);
    if (k > 1) packets_due.push_back(p1);
    if (has || last) items_sent++;
  endtask

  task automatic send_message(input int len);
    logic close_empty;
    close_empty = ($urandom_range(0, 3) == 0) || (len == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, -1, NO_PKT, NO_PKT);
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !close_empty,
                -1, NO_PKT, NO_PKT);
    end
    if (close_empty)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, -1, NO_PKT, NO_PKT);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
      if (packets_due.size() == 0) begin
        $display("%0t: unexpected packet, expected none, actual %p", $realtime, got);
        errors++;
      end else begin
        want = packets_due.pop_front();
        check_field("code_index", 8'(want.code), 8'(got.code));
        check_field("midi_byte_a", want.byte_a, got.byte_a);
        check_field("midi_byte_b", want.byte_b, got.byte_b);
        check_field("midi_byte_c", want.byte_c, got.byte_c);
        check_field("final_packet", 8'(want.fin), 8'(got.fin));
      end
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    id_len = '0;
    id_val = '{default: 8'h00};
    held = '{default: 8'h00};
    held_cnt = 0;
    in_msg = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_CFG)
        set_ids(directed[r].id_count, directed[r].id0, directed[r].id1, directed[r].id2);
      else
        send_item(directed[r].data, directed[r].has, directed[r].last,
                  directed[r].typed, directed[r].p0, directed[r].p1);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_ids(2'd0, 7'h00, 7'h00, 7'h00);
        1: set_ids(2'd3, 7'h7F, 7'h7F, 7'h7F);
        2: set_ids(2'd3, 7'h00, 7'h00, 7'h00);
        default: set_ids(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                         7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      endcase
      case (ph % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 69;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 69;
        end
        default: begin
          tx_idle_pct = 23;
          rx_stall_pct = 23;
        end
      endcase
      // long output hold-off so the block backs up into its input
      if (ph == 4) hold_req = 1'b1;
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) send_message($urandom_range(10, 40));
        else send_message($urandom_range(0, 6));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
